// File: src/gradient_noise_2d_fbm_unit_macros.svh
// Assertion macros for the gradient noise unit.
`ifndef GRADIENT_NOISE_2D_FBM_UNIT_MACROS_SVH
`define GRADIENT_NOISE_2D_FBM_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GNF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/gnf_pkg.sv
// Shared types, constants and table builder for the gradient noise unit.
`timescale 1ns / 1ps
package gnf_pkg;

	localparam int OCTAVES_DEF = 2;
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int FRAC_BITS_DEF = 16;

	localparam int COORD_W = 32;
	localparam int SEED_W = 32;
	localparam int OUT_W = 18;
	localparam int FRAC_W = 16;
	localparam int FREQ_W = 21;
	localparam int GRAD_W = 16;
	localparam int MAG_W = 15;
	localparam int DOT_W = 20;
	localparam int WGT_W = 18;
	localparam int INNER_W = 22;
	localparam int LERP_W = 22;
	localparam int NOISE_W = 22;
	localparam int PIPE_DEPTH = 14;

	localparam logic [FREQ_W-1:0] FREQ_BASE = 21'd5243;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
	localparam logic [31:0] HASH_C1 = 32'd3284157443;
	localparam logic [31:0] HASH_C2 = 32'd1911520717;
	localparam logic [31:0] HASH_C3 = 32'd2048419325;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] ROUND_Q16 = 64'd32768;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef grad_t grad_quad_t [4];
	typedef logic signed [NOISE_W-1:0] noise_t;

	typedef struct packed {
		logic [31:0] x0;
		logic [31:0] x1;
		logic [31:0] y0;
		logic [31:0] y1;
	} cell_t;

	typedef struct packed {
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
	} frac_pair_t;

	// Sine magnitude of the folded angle k / 2^lgd turns, Q1.14, rounded half-up.
	function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k, input int unsigned lgd);
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		r = 64'(k) << (32 - lgd);
		t = (r * HALF_PI_Q30) >> 30;
		t2 = (t * t) >> 30;
		term = ONE_Q30 - t2 / 72;
		term = ONE_Q30 - ((t2 * term) >> 30) / 42;
		term = ONE_Q30 - ((t2 * term) >> 30) / 20;
		term = ONE_Q30 - ((t2 * term) >> 30) / 6;
		term = (t * term) >> 30;
		return MAG_W'((term + ROUND_Q16) >> 16);
	endfunction

endpackage

// File: src/gnf_lattice.sv
// Octave frequency scaling and split of the point into lattice cell and fraction.
`timescale 1ns / 1ps
module gnf_lattice #(
	parameter int COORD_FRAC_BITS = gnf_pkg::FRAC_BITS_DEF,
	parameter int OCT_IDX = 0
) (
	input  logic                clk,
	input  logic                adv,
	input  gnf_pkg::coord_t     x_s1,
	input  gnf_pkg::coord_t     y_s1,
	output gnf_pkg::cell_t      cell_s3,
	output gnf_pkg::frac_pair_t frac_s3
);
	import gnf_pkg::*;

	localparam logic [FREQ_W-1:0] FREQ = FREQ_BASE << OCT_IDX;
	localparam int PROD_W = COORD_W + FREQ_W + 1;
	localparam int PX_W = PROD_W - 16;

	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [PX_W-1:0] px_s2, py_s2;
	logic signed [PX_W-1:0] sh_x, sh_y;
	logic [FRAC_W-1:0] fx, fy;

	assign prod_x = x_s1 * $signed({1'b0, FREQ});
	assign prod_y = y_s1 * $signed({1'b0, FREQ});

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= prod_x[PROD_W-1:16];
			py_s2 <= prod_y[PROD_W-1:16];
		end
	end

	assign sh_x = px_s2 >>> COORD_FRAC_BITS;
	assign sh_y = py_s2 >>> COORD_FRAC_BITS;

	if (COORD_FRAC_BITS >= FRAC_W) begin : g_frac_down
		assign fx = px_s2[COORD_FRAC_BITS-1 -: FRAC_W];
		assign fy = py_s2[COORD_FRAC_BITS-1 -: FRAC_W];
	end else begin : g_frac_up
		assign fx = {px_s2[COORD_FRAC_BITS-1:0], {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
		assign fy = {py_s2[COORD_FRAC_BITS-1:0], {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s3.x0 <= sh_x[31:0];
			cell_s3.x1 <= sh_x[31:0] + 32'd1;
			cell_s3.y0 <= sh_y[31:0];
			cell_s3.y1 <= sh_y[31:0] + 32'd1;
			frac_s3.fx <= fx;
			frac_s3.fy <= fy;
		end
	end

endmodule

// File: src/gnf_grad.sv
// Corner hash and sine table lookup giving the four corner gradients.
`timescale 1ns / 1ps
module gnf_grad #(
	parameter int SINE_TABLE_DEPTH = gnf_pkg::SINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [31:0]          seed,
	input  gnf_pkg::cell_t       cell_s3,
	output gnf_pkg::grad_quad_t  gx_s8,
	output gnf_pkg::grad_quad_t  gy_s8
);
	import gnf_pkg::*;

	localparam int LGD = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR = SINE_TABLE_DEPTH / 4;
	localparam logic [LGD-1:0] QTR_IDX = LGD'(QTR);
	localparam logic [LGD-2:0] QTR_FOLD = (LGD-1)'(QTR);

	logic [MAG_W-1:0] mag_tbl [QTR+1];

	for (genvar k = 0; k <= QTR; k++) begin : g_tbl
		localparam logic [MAG_W-1:0] MAG = sine_mag(k, LGD);
		assign mag_tbl[k] = MAG;
	end

	logic [31:0] ax_s4 [2];
	logic [31:0] by_s4 [2];
	logic [31:0] ax_s5 [2];
	logic [31:0] by_s5 [2];
	logic [31:0] ax_s6 [2];
	logic [31:0] b_s6 [4];
	logic [LGD-1:0] idx_s7 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s4[0] <= cell_s3.x0 * seed;
			ax_s4[1] <= cell_s3.x1 * seed;
			by_s4[0] <= cell_s3.y0 * seed;
			by_s4[1] <= cell_s3.y1 * seed;
			for (int j = 0; j < 2; j++) begin
				ax_s5[j] <= ax_s4[j] * HASH_C1;
				by_s5[j] <= by_s4[j];
				ax_s6[j] <= ax_s5[j];
			end
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_corner
		localparam int JX = c % 2;
		localparam int KY = c / 2;

		logic [31:0] b_mix, a_mix, a_fin;
		logic [LGD-1:0] jv [2];
		grad_t gv [2];

		assign b_mix = by_s5[KY] ^ {ax_s5[JX][15:0], ax_s5[JX][31:16]};
		assign a_mix = ax_s6[JX] ^ {b_s6[c][15:0], b_s6[c][31:16]};
		assign a_fin = a_mix * HASH_C3;

		always_ff @(posedge clk) begin
			if (adv) begin
				b_s6[c] <= b_mix * HASH_C2;
				idx_s7[c] <= a_fin[31 -: LGD];
			end
		end

		// jv[0] gives the cosine angle, jv[1] the sine angle
		assign jv[0] = idx_s7[c] + QTR_IDX;
		assign jv[1] = idx_s7[c];

		for (genvar h = 0; h < 2; h++) begin : g_trig
			logic [1:0] quad;
			logic [LGD-3:0] rem;
			logic [LGD-2:0] fold;
			logic [MAG_W-1:0] mag;

			assign quad = jv[h][LGD-1 -: 2];
			assign rem = jv[h][LGD-3:0];
			assign fold = quad[0] ? (QTR_FOLD - (LGD-1)'(rem)) : (LGD-1)'(rem);
			assign mag = mag_tbl[fold];
			assign gv[h] = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				gx_s8[c] <= gv[0];
				gy_s8[c] <= gv[1];
			end
		end
	end

endmodule

// File: src/gnf_interp.sv
// Smootherstep weights, corner dot products and bilinear blend for one octave.
`timescale 1ns / 1ps
module gnf_interp (
	input  logic                clk,
	input  logic                adv,
	input  gnf_pkg::frac_pair_t frac_s3,
	input  gnf_pkg::grad_quad_t gx_s8,
	input  gnf_pkg::grad_quad_t gy_s8,
	output gnf_pkg::noise_t     noise_s14
);
	import gnf_pkg::*;

	localparam logic signed [17:0] ONE_D = 18'sd65536;
	localparam logic signed [21:0] FIFTEEN_Q16 = 22'sd983040;
	localparam logic signed [INNER_W-1:0] TEN_Q16 = 22'sd655360;

	frac_pair_t fr_s4, fr_s5, fr_s6, fr_s7, fr_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s4 <= frac_s3;
			fr_s5 <= fr_s4;
			fr_s6 <= fr_s5;
			fr_s7 <= fr_s6;
			fr_s8 <= fr_s7;
		end
	end

	logic [FRAC_W-1:0] f_s3 [2];
	logic [FRAC_W-1:0] f_s4 [2];
	logic [FRAC_W-1:0] f2_s4 [2];
	logic signed [INNER_W-1:0] inner_s4 [2];
	logic [FRAC_W-1:0] f3_s5 [2];
	logic signed [INNER_W-1:0] inner_s5 [2];
	logic signed [WGT_W-1:0] w_s6 [2];

	assign f_s3[0] = frac_s3.fx;
	assign f_s3[1] = frac_s3.fy;
	assign f_s4[0] = fr_s4.fx;
	assign f_s4[1] = fr_s4.fy;

	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic signed [21:0] lin;
		logic signed [38:0] pin;
		logic [31:0] sq;
		logic [31:0] cube;
		logic signed [38:0] pw;

		assign lin = $signed(22'(f_s3[a]) * 22'd6) - FIFTEEN_Q16;
		assign pin = $signed({1'b0, f_s3[a]}) * lin;
		assign sq = 32'(f_s3[a]) * 32'(f_s3[a]);
		assign cube = 32'(f2_s4[a]) * 32'(f_s4[a]);
		assign pw = inner_s5[a] * $signed({1'b0, f3_s5[a]});

		always_ff @(posedge clk) begin
			if (adv) begin
				f2_s4[a] <= sq[31:16];
				inner_s4[a] <= INNER_W'(pin >>> 16) + TEN_Q16;
				f3_s5[a] <= cube[31:16];
				inner_s5[a] <= inner_s4[a];
				w_s6[a] <= WGT_W'(pw >>> 16);
			end
		end
	end

	logic signed [WGT_W-1:0] wy_s7, wy_s8, wy_s9, wy_s10;
	logic signed [WGT_W-1:0] wx_s7, wx_s8, wx_s9, wx_s10, wx_s11, wx_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			wy_s7 <= w_s6[1];
			wy_s8 <= wy_s7;
			wy_s9 <= wy_s8;
			wy_s10 <= wy_s9;
			wx_s7 <= w_s6[0];
			wx_s8 <= wx_s7;
			wx_s9 <= wx_s8;
			wx_s10 <= wx_s9;
			wx_s11 <= wx_s10;
			wx_s12 <= wx_s11;
		end
	end

	logic signed [33:0] pgx_s9 [4];
	logic signed [33:0] pgy_s9 [4];
	logic signed [DOT_W-1:0] dot_s10 [4];

	for (genvar c = 0; c < 4; c++) begin : g_dot
		logic signed [17:0] dx, dy;
		logic signed [34:0] dsum;

		assign dx = $signed({2'b0, fr_s8.fx}) - ((c % 2 == 1) ? ONE_D : 18'sd0);
		assign dy = $signed({2'b0, fr_s8.fy}) - ((c / 2 == 1) ? ONE_D : 18'sd0);
		assign dsum = 35'(pgx_s9[c]) + 35'(pgy_s9[c]);

		always_ff @(posedge clk) begin
			if (adv) begin
				pgx_s9[c] <= gx_s8[c] * dx;
				pgy_s9[c] <= gy_s8[c] * dy;
				dot_s10[c] <= DOT_W'(dsum >>> 14);
			end
		end
	end

	logic signed [DOT_W-1:0] base_s11 [2];
	logic signed [DOT_W+WGT_W:0] ly_prod_s11 [2];
	logic signed [LERP_W-1:0] ly_s12 [2];

	for (genvar i = 0; i < 2; i++) begin : g_lerp_y
		logic signed [DOT_W:0] diff;

		assign diff = (DOT_W+1)'(dot_s10[i+2]) - (DOT_W+1)'(dot_s10[i]);

		always_ff @(posedge clk) begin
			if (adv) begin
				ly_prod_s11[i] <= diff * wy_s10;
				base_s11[i] <= dot_s10[i];
				ly_s12[i] <= LERP_W'(base_s11[i]) + LERP_W'(ly_prod_s11[i] >>> 16);
			end
		end
	end

	logic signed [LERP_W:0] lx_diff;
	logic signed [LERP_W+WGT_W:0] lx_prod_s13;
	logic signed [LERP_W-1:0] ly0_s13;

	assign lx_diff = (LERP_W+1)'(ly_s12[1]) - (LERP_W+1)'(ly_s12[0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			lx_prod_s13 <= lx_diff * wx_s12;
			ly0_s13 <= ly_s12[0];
			noise_s14 <= NOISE_W'(ly0_s13) + NOISE_W'(lx_prod_s13 >>> 16);
		end
	end

endmodule

// File: src/gradient_noise_2d_fbm_unit.sv
// Top level of the two-octave 2D gradient noise unit.
//
//  port group   dir  handshake          word
//  in           in   in_valid/in_stall  x_coord, y_coord (Q16.16)
//  out          out  out_valid/out_stall noise_value (Q2.16, saturated)
//  cfg          in   cfg_valid/cfg_ready hash_seed
//
// One word in per cycle, one out per cycle, while no output stall holds the pipeline;
// 15 register stages, from the x_s1/y_s1 input registers to noise_q.
// The fixed depth of the multiply chain (scale, hash, dot, blend) sets the latency.
// A stall on the output freezes every stage; in_stall follows it when a result waits.
// Reset clears all valid bits and loads the seed register seed_q with 1.
`timescale 1ns / 1ps
module gradient_noise_2d_fbm_unit #(
	parameter int OCTAVES = gnf_pkg::OCTAVES_DEF,
	parameter int SINE_TABLE_DEPTH = gnf_pkg::SINE_DEPTH_DEF,
	parameter int COORD_FRAC_BITS = gnf_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [31:0]          x_coord,
	input  logic signed [31:0]          y_coord,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [17:0]          noise_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [31:0]                 hash_seed
);
	import gnf_pkg::*;
	`include "gradient_noise_2d_fbm_unit_macros.svh"

	localparam int SUM_W = NOISE_W + 2 + $clog2(OCTAVES);
	localparam logic signed [SUM_W-1:0] HALF_BIAS = SUM_W'(65536);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(131071);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(131072);

	logic adv;
	logic [SEED_W-1:0] seed_q;
	logic [PIPE_DEPTH:1] v_q;
	logic out_valid_q;
	logic signed [OUT_W-1:0] noise_q;
	coord_t x_s1, y_s1;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign noise_value = noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= hash_seed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_q <= {v_q[PIPE_DEPTH-1:1], in_valid};
			out_valid_q <= v_q[PIPE_DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_coord;
			y_s1 <= y_coord;
		end
	end

	noise_t noise_s14 [OCTAVES];
	logic signed [SUM_W-1:0] wn [OCTAVES];

	for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
		cell_t cell_s3;
		frac_pair_t frac_s3;
		grad_quad_t gx_s8, gy_s8;

		gnf_lattice #(
			.COORD_FRAC_BITS(COORD_FRAC_BITS),
			.OCT_IDX(o)
		) u_lattice (
			.clk(clk),
			.adv(adv),
			.x_s1(x_s1),
			.y_s1(y_s1),
			.cell_s3(cell_s3),
			.frac_s3(frac_s3)
		);

		gnf_grad #(
			.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
		) u_grad (
			.clk(clk),
			.adv(adv),
			.seed(seed_q),
			.cell_s3(cell_s3),
			.gx_s8(gx_s8),
			.gy_s8(gy_s8)
		);

		gnf_interp u_interp (
			.clk(clk),
			.adv(adv),
			.frac_s3(frac_s3),
			.gx_s8(gx_s8),
			.gy_s8(gy_s8),
			.noise_s14(noise_s14[o])
		);

		if (o == 0) begin : g_w2
			assign wn[o] = SUM_W'(noise_s14[o]) <<< 1;
		end else begin : g_wn
			assign wn[o] = SUM_W'(noise_s14[o]) >>> (o - 1);
		end
	end

	logic signed [SUM_W-1:0] sum, half;

	always_comb begin
		sum = '0;
		for (int o = 0; o < OCTAVES; o++) begin
			sum = sum + wn[o];
		end
		half = (sum + HALF_BIAS) >>> 1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (half > SAT_HI) begin
				noise_q <= OUT_W'(SAT_HI);
			end else if (half < SAT_LO) begin
				noise_q <= OUT_W'(SAT_LO);
			end else begin
				noise_q <= OUT_W'(half);
			end
		end
	end

	`GNF_ASSERT_NEXT(a_stall_freeze, out_valid_q && out_stall, $stable(v_q),
		"pipeline valid bits moved under output stall")
	`GNF_ASSERT_NEXT(a_valid_shift, !in_stall, v_q[2] == $past(v_q[1]),
		"valid bit lost between first stages")
	`GNF_ASSERT_NOW(a_out_origin, $rose(out_valid_q), $past(v_q[PIPE_DEPTH]),
		"output valid without a last-stage word")
	`GNF_ASSERT_NEXT(a_seed_load, cfg_valid && cfg_ready, seed_q == $past(hash_seed),
		"seed register missed a write")

endmodule
